// ===== design/edd_pkg.sv =====
// shared types, constants and arithmetic helpers for the error diffusion ditherer
// no dependencies
package edd_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int WIDTH_W     = COL_W + 1;
	localparam int MEM_AW      = COL_W + 1;
	localparam int MEM_DEPTH   = 2 * MAX_WIDTH;
	localparam int PIX_W       = 8;
	localparam int THR_W       = 8;
	localparam int ERR_BITS    = 16;
	localparam int PROD_W      = ERR_BITS + 5;
	localparam int ERR_MAX     = 2 ** (ERR_BITS - 1) - 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = WIDTH_W;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b1;

	localparam logic [THR_W-1:0]   THRESHOLD_RESET = THR_W'(127);
	localparam logic [WIDTH_W-1:0] WIDTH_RESET     = WIDTH_W'(MAX_WIDTH);

	localparam logic signed [PROD_W-1:0] BIAS_BASE = PROD_W'(127);
	localparam logic signed [PROD_W-1:0] SUM_WHITE = PROD_W'(255);
	localparam logic signed [PROD_W-1:0] SUM_BLACK = PROD_W'(0);
	localparam logic [PIX_W-1:0] LEVEL_WHITE = PIX_W'(255);
	localparam logic [PIX_W-1:0] LEVEL_BLACK = PIX_W'(0);

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             frame_start;
		logic [COL_W-1:0] col;
		logic             last;
	} queue_word_t;

	function automatic logic signed [ERR_BITS-1:0] sat_err(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'(ERR_MAX);
		lo = -hi - PROD_W'(1);
		if (v > hi) begin
			return hi[ERR_BITS-1:0];
		end else if (v < lo) begin
			return lo[ERR_BITS-1:0];
		end
		return v[ERR_BITS-1:0];
	endfunction

	// divide by 16, rounding toward zero
	function automatic logic signed [PROD_W-1:0] div16(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] t;
		t = v + (v[PROD_W-1] ? PROD_W'(15) : PROD_W'(0));
		return t >>> 4;
	endfunction

endpackage

// ===== design/edd_front.sv =====
// front end: accepts pixel words, tracks the column and flags the last pixel of a row
// depends on edd_pkg
module edd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pixel_valid,
	input  logic [edd_pkg::PIX_W-1:0]     pixel,
	input  logic                          frame_start,
	input  logic [edd_pkg::WIDTH_W-1:0]   image_width,
	input  logic                          queue_full,
	output logic                          push,
	output edd_pkg::queue_word_t          word
);

	logic [edd_pkg::COL_W-1:0]   column_q;
	logic [edd_pkg::COL_W-1:0]   col;
	logic [edd_pkg::WIDTH_W-1:0] w_eff;
	logic [edd_pkg::WIDTH_W-1:0] col_next;
	logic                        last;

	always_comb begin
		priority if (image_width == '0) begin
			w_eff = edd_pkg::WIDTH_W'(1);
		end else if (image_width > edd_pkg::WIDTH_W'(edd_pkg::MAX_WIDTH)) begin
			w_eff = edd_pkg::WIDTH_W'(edd_pkg::MAX_WIDTH);
		end else begin
			w_eff = image_width;
		end
	end

	assign col      = frame_start ? '0 : column_q;
	assign col_next = edd_pkg::WIDTH_W'(col) + edd_pkg::WIDTH_W'(1);
	assign last     = (col_next >= w_eff);
	assign push     = pixel_valid & ~queue_full;

	always_comb begin
		word.pixel       = pixel;
		word.frame_start = frame_start;
		word.col         = col;
		word.last        = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
		end else if (push) begin
			column_q <= last ? '0 : col_next[edd_pkg::COL_W-1:0];
		end
	end

endmodule

// ===== design/edd_queue.sv =====
// short queue between front and back end of the ditherer
// depends on edd_pkg
module edd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  edd_pkg::queue_word_t push_word,
	input  logic                 pop,
	output logic                 full,
	output logic                 head_valid,
	output edd_pkg::queue_word_t head
);

	edd_pkg::queue_word_t          slot_q [edd_pkg::QUEUE_DEPTH];
	logic [edd_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [edd_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [edd_pkg::QPTR_W:0]      count_q;
	logic                          do_push;
	logic                          do_pop;

	assign full       = (count_q == (edd_pkg::QPTR_W+1)'(edd_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign do_push    = push & ~full;
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + edd_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + edd_pkg::QPTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (edd_pkg::QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (edd_pkg::QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/edd_back.sv =====
// back end: error store lookup, threshold decision, error diffusion and output register
// depends on edd_pkg; holds the ping-pong row error memory
module edd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [edd_pkg::THR_W-1:0]   threshold,
	input  logic                        head_valid,
	input  edd_pkg::queue_word_t        head,
	output logic                        pop,
	input  logic                        level_stall,
	output logic                        level_valid,
	output logic [edd_pkg::PIX_W-1:0]   level,
	output logic                        row_end
);

	logic signed [edd_pkg::ERR_BITS-1:0] err_mem [edd_pkg::MEM_DEPTH];

	logic                                v_s1;
	edd_pkg::queue_word_t                word_s1;
	logic signed [edd_pkg::ERR_BITS-1:0] rd_data_s1;
	logic                                byp_s1;
	logic signed [edd_pkg::ERR_BITS-1:0] byp_data_s1;

	logic                                bank_q;
	logic                                have_row_q;
	logic [edd_pkg::COL_W-1:0]           last_col_q;
	logic signed [edd_pkg::ERR_BITS-1:0] tail_q;
	logic signed [edd_pkg::ERR_BITS-1:0] right_q;
	logic signed [edd_pkg::ERR_BITS-1:0] acc_m_q;
	logic signed [edd_pkg::ERR_BITS-1:0] acc_0_q;

	logic                                out_valid_q;
	logic [edd_pkg::PIX_W-1:0]           level_q;
	logic                                row_end_q;

	logic                                adv;
	logic                                fire;
	logic                                wr_en;
	logic [edd_pkg::MEM_AW-1:0]          wr_addr;
	logic [edd_pkg::MEM_AW-1:0]          rd_addr;
	logic                                rd_bank;

	logic                                fs;
	logic                                have;
	logic signed [edd_pkg::ERR_BITS-1:0] right_eff;
	logic signed [edd_pkg::ERR_BITS-1:0] acc_m_eff;
	logic signed [edd_pkg::ERR_BITS-1:0] acc_0_eff;
	logic signed [edd_pkg::ERR_BITS-1:0] mem_val;
	logic signed [edd_pkg::ERR_BITS-1:0] entry;
	logic signed [edd_pkg::ERR_BITS-1:0] cur_sat;
	logic signed [edd_pkg::PROD_W-1:0]   sum;
	logic signed [edd_pkg::PROD_W-1:0]   err;
	logic signed [edd_pkg::PROD_W-1:0]   e1;
	logic signed [edd_pkg::PROD_W-1:0]   e3;
	logic signed [edd_pkg::PROD_W-1:0]   e5;
	logic signed [edd_pkg::PROD_W-1:0]   e7;
	logic                                white;
	logic signed [edd_pkg::ERR_BITS-1:0] a_prev;
	logic signed [edd_pkg::ERR_BITS-1:0] a_cur;
	logic signed [edd_pkg::ERR_BITS-1:0] a_next;
	logic signed [edd_pkg::ERR_BITS-1:0] right_next;

	assign adv  = ~out_valid_q | ~level_stall;
	assign pop  = adv & head_valid;
	assign fire = adv & v_s1;

	// next-row writes go to the other bank; a row end swaps the banks
	assign wr_en   = fire & (word_s1.col != '0);
	assign wr_addr = {~bank_q, word_s1.col - edd_pkg::COL_W'(1)};
	assign rd_bank = bank_q ^ (v_s1 & word_s1.last);
	assign rd_addr = {rd_bank, head.col};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			err_mem[wr_addr] <= a_prev;
		end
		if (pop) begin
			rd_data_s1 <= err_mem[rd_addr];
		end
	end

	// error lookup for the current column
	always_comb begin
		fs        = word_s1.frame_start;
		have      = have_row_q & ~fs;
		right_eff = fs ? '0 : right_q;
		acc_m_eff = fs ? '0 : acc_m_q;
		acc_0_eff = fs ? '0 : acc_0_q;
		mem_val   = byp_s1 ? byp_data_s1 : rd_data_s1;
		priority if (!have || word_s1.col > last_col_q) begin
			entry = '0;
		end else if (word_s1.col == last_col_q) begin
			entry = tail_q;
		end else begin
			entry = mem_val;
		end
	end

	// decision and diffusion shares
	always_comb begin
		cur_sat = edd_pkg::sat_err(edd_pkg::PROD_W'(entry) + edd_pkg::PROD_W'(right_eff));
		sum     = edd_pkg::PROD_W'(cur_sat) + $signed(edd_pkg::PROD_W'(word_s1.pixel))
		        + edd_pkg::BIAS_BASE - $signed(edd_pkg::PROD_W'(threshold));
		white   = (sum > $signed(edd_pkg::PROD_W'(threshold)));
		err     = sum - (white ? edd_pkg::SUM_WHITE : edd_pkg::SUM_BLACK);
		e1      = edd_pkg::div16(err);
		e3      = edd_pkg::div16((err <<< 1) + err);
		e5      = edd_pkg::div16((err <<< 2) + err);
		e7      = edd_pkg::div16((err <<< 3) - err);
		a_prev     = edd_pkg::sat_err(edd_pkg::PROD_W'(acc_m_eff) + e3);
		a_cur      = edd_pkg::sat_err(edd_pkg::PROD_W'(acc_0_eff) + e5);
		a_next     = edd_pkg::sat_err(e1);
		right_next = edd_pkg::sat_err(e7);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_s1     <= head;
			byp_s1      <= wr_en && (wr_addr == rd_addr);
			byp_data_s1 <= a_prev;
		end
		if (fire) begin
			level_q   <= white ? edd_pkg::LEVEL_WHITE : edd_pkg::LEVEL_BLACK;
			row_end_q <= word_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			bank_q      <= 1'b0;
			have_row_q  <= 1'b0;
			last_col_q  <= '0;
			tail_q      <= '0;
			right_q     <= '0;
			acc_m_q     <= '0;
			acc_0_q     <= '0;
		end else begin
			if (adv) begin
				v_s1        <= head_valid;
				out_valid_q <= v_s1;
			end
			if (fire) begin
				if (word_s1.last) begin
					tail_q     <= a_cur;
					last_col_q <= word_s1.col;
					have_row_q <= 1'b1;
					bank_q     <= ~bank_q;
					right_q    <= '0;
					acc_m_q    <= '0;
					acc_0_q    <= '0;
				end else begin
					have_row_q <= have;
					right_q    <= right_next;
					acc_m_q    <= a_cur;
					acc_0_q    <= a_next;
				end
			end
		end
	end

	assign level_valid = out_valid_q;
	assign level       = level_q;
	assign row_end     = row_end_q;

endmodule

// ===== design/error_diffusion_dither.sv =====
// error diffusion ditherer top level: configuration registers, front end, queue, back end
// depends on edd_pkg, edd_front, edd_queue, edd_back
//
// Grey pixels come in raster order on the pixel channel (pixel_valid / pixel_stall,
// with pixel and frame_start); frame_start marks the first pixel of an image and
// clears all diffused error. Each pixel gives one word on the level channel
// (level_valid / level_stall, with level and row_end), level being 0 or 255.
// Configuration: cfg_index 0 is the threshold, 1 the image width; cfg_ready is
// always high, and writes belong in idle time between images.
// A result passes through a queue slot, the stage-one and the output register.
// Throughput: one pixel per clock while level_stall is low, set by the registered loop
// that forwards the right-hand error share from one pixel to the next; one error
// memory read per pixel and one write per pixel outside column 0.
// A four-word queue separates the pixel side from the result side. While level_stall
// is high and a result is shown, the result register and the back end hold, the queue
// fills, and pixel_stall rises once it is full.
// Reset: threshold 127, width 1024, all error stores read as zero; no clearing
// pass, the block takes pixels in the first cycle after reset.
module error_diffusion_dither (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pixel_valid,
	output logic                             pixel_stall,
	input  logic [edd_pkg::PIX_W-1:0]        pixel,
	input  logic                             frame_start,
	output logic                             level_valid,
	input  logic                             level_stall,
	output logic [edd_pkg::PIX_W-1:0]        level,
	output logic                             row_end,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [edd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [edd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [edd_pkg::THR_W-1:0]   threshold_q;
	logic [edd_pkg::WIDTH_W-1:0] image_width_q;

	logic                        push;
	edd_pkg::queue_word_t        push_word;
	logic                        queue_full;
	logic                        head_valid;
	edd_pkg::queue_word_t        head;
	logic                        pop;

	assign cfg_ready   = 1'b1;
	assign pixel_stall = queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q   <= edd_pkg::THRESHOLD_RESET;
			image_width_q <= edd_pkg::WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				edd_pkg::REG_THRESHOLD:   threshold_q   <= cfg_data[edd_pkg::THR_W-1:0];
				edd_pkg::REG_IMAGE_WIDTH: image_width_q <= cfg_data[edd_pkg::WIDTH_W-1:0];
				default:                  threshold_q   <= threshold_q;
			endcase
		end
	end

	edd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel       (pixel),
		.frame_start (frame_start),
		.image_width (image_width_q),
		.queue_full  (queue_full),
		.push        (push),
		.word        (push_word)
	);

	edd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_word  (push_word),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head       (head)
	);

	edd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.threshold   (threshold_q),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.level_stall (level_stall),
		.level_valid (level_valid),
		.level       (level),
		.row_end     (row_end)
	);

endmodule
